[rtl/bpf_pkg.sv]
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared types and constants for the boot packet framer.
// ----------------------------------------------------------------------------
package bpf_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_CMD     = 4'd0;
  localparam step_t STEP_LEN     = 4'd1;
  localparam step_t STEP_ADDR3   = 4'd2;
  localparam step_t STEP_ADDR2   = 4'd3;
  localparam step_t STEP_ADDR1   = 4'd4;
  localparam step_t STEP_ADDR0   = 4'd5;
  localparam step_t STEP_PAYLOAD = 4'd6;
  localparam step_t STEP_SUM_HI  = 4'd7;
  localparam step_t STEP_SUM_LO  = 4'd8;

  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [7:0]  len_minus_one;
    logic [31:0] target_addr;
    logic [7:0]  payload;
    logic        first;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_item_t;

  // Classified request as held in the queue between front and back
  typedef struct packed {
    in_item_t item;
    step_t    start_step;
  } job_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

[rtl/bpf_front.sv]
// ----------------------------------------------------------------------------
// bpf_front
// Accepts input requests, works out the first step of each and queues them.
// ----------------------------------------------------------------------------
module bpf_front #(
  parameter int QUEUE_DEPTH = bpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  bpf_pkg::in_item_t in_data,
  output bpf_pkg::head_t    head,
  input  logic              head_pop
);
  import bpf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;
  job_t             new_job;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = head_pop && (count_r != '0);

  always_comb begin
    new_job.item       = in_data;
    new_job.start_step = in_data.first ? STEP_CMD : STEP_PAYLOAD;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head.valid = (count_r != '0);
  assign head.job   = mem[rd_ptr_r];

endmodule

[rtl/bpf_back.sv]
// ----------------------------------------------------------------------------
// bpf_back
// Steps through header, payload and checksum bytes of each queued request,
// keeps the running sum and drives the output register.
// ----------------------------------------------------------------------------
module bpf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bpf_pkg::head_t     head,
  output logic               head_pop,
  output logic               empty,
  input  logic               pop,
  output bpf_pkg::out_item_t out_data
);
  import bpf_pkg::*;

  step_t      step_r;
  logic       in_prog_r;
  logic [15:0] sum_r;
  logic       out_valid_r;
  out_item_t  out_r;

  step_t      cur_step;
  logic       advance;
  logic       done;
  logic [7:0] byte_sel;
  in_item_t   it;

  assign it       = head.job.item;
  assign cur_step = in_prog_r ? step_r : head.job.start_step;
  assign advance  = head.valid && (!out_valid_r || pop);
  assign done     = (cur_step == STEP_SUM_LO) || (cur_step == STEP_PAYLOAD && !it.last);
  assign head_pop = advance && done;

  always_comb begin
    unique case (cur_step)
      STEP_CMD:     byte_sel = it.cmd;
      STEP_LEN:     byte_sel = it.len_minus_one;
      STEP_ADDR3:   byte_sel = it.target_addr[31:24];
      STEP_ADDR2:   byte_sel = it.target_addr[23:16];
      STEP_ADDR1:   byte_sel = it.target_addr[15:8];
      STEP_ADDR0:   byte_sel = it.target_addr[7:0];
      STEP_PAYLOAD: byte_sel = it.payload;
      STEP_SUM_HI:  byte_sel = sum_r[15:8];
      STEP_SUM_LO:  byte_sel = sum_r[7:0] & BYTE_MASK;
      default:      byte_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.out_byte  <= byte_sel;
      out_r.frame_end <= (cur_step == STEP_SUM_LO);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_CMD;
      in_prog_r   <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        if (done) begin
          in_prog_r <= 1'b0;
        end else begin
          in_prog_r <= 1'b1;
          step_r    <= cur_step + 1'b1;
        end
        if (cur_step == STEP_CMD) begin
          sum_r <= {8'h00, byte_sel};
        end else if (cur_step == STEP_SUM_LO) begin
          sum_r <= '0;
        end else if (cur_step != STEP_SUM_HI) begin
          sum_r <= sum_r + {8'h00, byte_sel};
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

endmodule

[rtl/boot_packet_framer.sv]
// ----------------------------------------------------------------------------
// boot_packet_framer
// Path: an accepted request is queued, then its first byte goes to the output
// register. Throughput: one output byte per cycle while pop keeps up;
// a request gives 1, 3, 7 or 9 bytes, set by its first and last flags.
// Reset: synchronous active-low rst_n empties the queue and output register
// and clears the running sum.
// ----------------------------------------------------------------------------
module boot_packet_framer #(
  parameter int QUEUE_DEPTH = bpf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bpf_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output bpf_pkg::out_item_t out_data
);
  import bpf_pkg::*;

  head_t head;
  logic  head_pop;

  bpf_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .head     (head),
    .head_pop (head_pop)
  );

  bpf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_pop (head_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
